// File: src/rie_pkg.sv
package rie_pkg;

    typedef enum logic [5:0] {
        OP_TRAP, OP_NOP, OP_RTI, OP_ADDI, OP_SUBI, OP_XORI, OP_ANDNI, OP_ROLI,
        OP_SLLI, OP_RORI, OP_SRLI, OP_ST, OP_LD, OP_STU, OP_BTR, OP_ADD,
        OP_SUB, OP_XOR, OP_ANDN, OP_ROL, OP_SLL, OP_ROR, OP_SRL, OP_SEQ,
        OP_SLT, OP_SLE, OP_SCO, OP_BEQZ, OP_BNEZ, OP_BLTZ, OP_BGEZ, OP_LBI,
        OP_SLBI, OP_J, OP_JR, OP_JAL, OP_JALR
    } op_t;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [2:0]  LINK_REG  = 3'd7;
    localparam logic [15:0] TRAP_PC   = 16'h0002;
    localparam logic [15:0] PC_STEP   = 16'h0002;

    typedef struct packed {
        logic [5:0]  cmd;
        logic [2:0]  src_index;
        logic [2:0]  second_index;
        logic [2:0]  dest_index;
        logic [4:0]  imm_five;
        logic [7:0]  imm_eight;
        logic [10:0] displacement;
    } instr_t;

    typedef struct packed {
        logic        wb_valid;
        logic [2:0]  wb_index;
        logic [15:0] wb_value;
        logic [1:0]  mem_kind;
        logic [15:0] mem_address;
        logic [15:0] mem_data;
        logic [15:0] next_pc;
        logic        trapped;
    } result_t;

endpackage

// File: src/rie_chan_if.sv
interface rie_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/rie_alu.sv
module rie_alu
    import rie_pkg::*;
(
    input  instr_t      instr,
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  logic [15:0] d,
    input  logic [15:0] pc,
    input  logic [15:0] epc,
    output result_t     res
);

    logic [15:0] pc2;
    logic [15:0] imm5_s;
    logic [15:0] imm5_z;
    logic [15:0] imm8_s;
    logic [15:0] disp_s;
    logic [15:0] addr;
    logic [3:0]  sh_i;
    logic [3:0]  sh_b;
    logic [31:0] rl_i;
    logic [31:0] rl_b;
    logic [31:0] rr_i;
    logic [31:0] rr_b;
    logic [16:0] sum_ab;
    logic [15:0] rev;
    op_t         op;

    always_comb
    begin
        pc2    = pc + PC_STEP;
        imm5_s = {{11{instr.imm_five[4]}}, instr.imm_five};
        imm5_z = {11'd0, instr.imm_five};
        imm8_s = {{8{instr.imm_eight[7]}}, instr.imm_eight};
        disp_s = {{5{instr.displacement[10]}}, instr.displacement};
        addr   = a + imm5_s;
        sh_i   = instr.imm_five[3:0];
        sh_b   = b[3:0];
        rl_i   = {a, a} << sh_i;
        rl_b   = {a, a} << sh_b;
        rr_i   = {a, a} >> sh_i;
        rr_b   = {a, a} >> sh_b;
        sum_ab = {1'b0, a} + {1'b0, b};
        rev    = {<<{a}};
        op     = op_t'(instr.cmd);

        res = '0;
        res.next_pc = pc2;
        case (op)
            OP_NOP: ;
            OP_RTI: res.next_pc = epc;
            OP_ADDI: begin res.wb_value = addr; end
            OP_SUBI: res.wb_value = imm5_s - a;
            OP_XORI: res.wb_value = a ^ imm5_z;
            OP_ANDNI: res.wb_value = a & ~imm5_z;
            OP_ROLI: res.wb_value = rl_i[31:16];
            OP_SLLI: res.wb_value = a << sh_i;
            OP_RORI: res.wb_value = rr_i[15:0];
            OP_SRLI: res.wb_value = a >> sh_i;
            OP_ST:
            begin
                res.mem_kind    = MEM_STORE;
                res.mem_address = addr;
                res.mem_data    = d;
                res.wb_value    = d;
            end
            OP_LD:
            begin
                res.mem_kind    = MEM_LOAD;
                res.mem_address = addr;
            end
            OP_STU:
            begin
                res.mem_kind    = MEM_STORE;
                res.mem_address = addr;
                res.mem_data    = d;
                res.wb_value    = addr;
            end
            OP_BTR: res.wb_value = rev;
            OP_ADD: res.wb_value = sum_ab[15:0];
            OP_SUB: res.wb_value = b - a;
            OP_XOR: res.wb_value = a ^ b;
            OP_ANDN: res.wb_value = a & ~b;
            OP_ROL: res.wb_value = rl_b[31:16];
            OP_SLL: res.wb_value = a << sh_b;
            OP_ROR: res.wb_value = rr_b[15:0];
            OP_SRL: res.wb_value = a >> sh_b;
            OP_SEQ: res.wb_value = {15'd0, a == b};
            OP_SLT: res.wb_value = {15'd0, $signed(a) < $signed(b)};
            OP_SLE: res.wb_value = {15'd0, $signed(a) <= $signed(b)};
            OP_SCO: res.wb_value = {15'd0, sum_ab[16]};
            OP_BEQZ: if (a == 16'd0) res.next_pc = pc2 + imm8_s;
            OP_BNEZ: if (a != 16'd0) res.next_pc = pc2 + imm8_s;
            OP_BLTZ: if (a[15]) res.next_pc = pc2 + imm8_s;
            OP_BGEZ: if (!a[15]) res.next_pc = pc2 + imm8_s;
            OP_LBI: res.wb_value = imm8_s;
            OP_SLBI: res.wb_value = {a[7:0], instr.imm_eight};
            OP_J: res.next_pc = pc2 + disp_s;
            OP_JR: res.next_pc = a + imm8_s;
            OP_JAL:
            begin
                res.wb_value = pc2;
                res.next_pc  = pc2 + disp_s;
            end
            OP_JALR:
            begin
                res.wb_value = pc2;
                res.next_pc  = a + imm8_s;
            end
            default:
            begin
                res.trapped = 1'b1;
                res.next_pc = TRAP_PC;
            end
        endcase

        // Write-back target follows the operation class.
        case (op)
            OP_ADDI, OP_SUBI, OP_XORI, OP_ANDNI, OP_ROLI, OP_SLLI, OP_RORI, OP_SRLI,
            OP_LD, OP_BTR, OP_ADD, OP_SUB, OP_XOR, OP_ANDN, OP_ROL, OP_SLL, OP_ROR,
            OP_SRL, OP_SEQ, OP_SLT, OP_SLE, OP_SCO:
            begin
                res.wb_valid = 1'b1;
                res.wb_index = instr.dest_index;
            end
            OP_STU, OP_LBI, OP_SLBI:
            begin
                res.wb_valid = 1'b1;
                res.wb_index = instr.src_index;
            end
            OP_JAL, OP_JALR:
            begin
                res.wb_valid = 1'b1;
                res.wb_index = LINK_REG;
            end
            default: ;
        endcase
    end

endmodule

// File: src/risc16_instruction_execute_core.sv
// Execute stage of a 16-bit RISC with eight general registers, PC, exception
// PC and a word-addressed data memory.
// Channel instr carries one decoded instruction per transaction; channel result
// returns one transaction per instruction with the register write-back, the
// memory access and the next PC, in instruction order.
// The register file is read into the first stage; execute and the data memory
// read are registered into the output stage. One instruction is accepted per
// cycle unless a full, stalled pipeline or the memory clear holds it; results
// of back-to-back instructions are forwarded from the output stage, so no bubbles.
// Register file writes retire when the result transaction completes.
// After reset the data memory is cleared one word per cycle, all
// 2**DMEM_ADDR_BITS words (4096 at the default); instr.ready stays low
// during that pass. Registers and both PCs reset to zero.
// When the receiver stalls, the output stage holds and the pipeline fills;
// instr.ready drops once both stages are occupied.
module risc16_instruction_execute_core
    import rie_pkg::*;
#(
    parameter int DMEM_ADDR_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    rie_chan_if.sink   instr,
    rie_chan_if.source result
);

    localparam int DMEM_DEPTH = 1 << DMEM_ADDR_BITS;

    logic [15:0] rf_ab_mem [8];
    logic [15:0] rf_d_mem [8];
    logic [15:0] dmem [DMEM_DEPTH];
    logic [7:0]  rf_vld_reg;

    logic [DMEM_ADDR_BITS-1:0] clr_cnt_reg;
    logic                      clearing_reg;

    logic        s1_valid_reg;
    instr_t      s1_instr_reg;
    logic [15:0] rd_a_reg, rd_b_reg, rd_d_reg;
    logic        vld_a_reg, vld_b_reg, vld_d_reg;
    logic        ovr_a_reg, ovr_b_reg, ovr_d_reg;
    logic [15:0] ovr_val_reg;

    logic        s2_valid_reg;
    result_t     s2_res_reg;
    logic        s2_load_reg;
    logic [15:0] dmem_rd_reg;

    logic [15:0] pc_reg;
    logic [15:0] epc_reg;

    logic        in_fire, out_fire, s1_adv, s2_ready;
    logic [15:0] s2_wb_value;
    logic [15:0] op_a, op_b, op_d;
    result_t     ex_res;
    instr_t      in_instr;
    logic [DMEM_ADDR_BITS-1:0] ex_addr;

    function automatic logic [15:0] pick(
        input logic [2:0]  idx,
        input logic [15:0] rd,
        input logic        vld,
        input logic        ovr,
        input logic [15:0] ovr_val,
        input logic        s2_hit_v,
        input logic [2:0]  s2_idx,
        input logic [15:0] s2_val
    );
        logic [15:0] v;
        v = vld ? rd : 16'd0;
        if (ovr)
            v = ovr_val;
        if (s2_hit_v && s2_idx == idx)
            v = s2_val;
        return v;
    endfunction

    assign in_instr = instr.data;
    assign s2_ready = !s2_valid_reg || result.ready;
    assign out_fire = s2_valid_reg && result.ready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign instr.ready = !clearing_reg && (!s1_valid_reg || s2_ready);
    assign in_fire  = instr.valid && instr.ready;

    assign s2_wb_value = s2_load_reg ? dmem_rd_reg : s2_res_reg.wb_value;

    always_comb
    begin
        op_a = pick(s1_instr_reg.src_index, rd_a_reg, vld_a_reg, ovr_a_reg, ovr_val_reg,
                    s2_valid_reg && s2_res_reg.wb_valid, s2_res_reg.wb_index, s2_wb_value);
        op_b = pick(s1_instr_reg.second_index, rd_b_reg, vld_b_reg, ovr_b_reg, ovr_val_reg,
                    s2_valid_reg && s2_res_reg.wb_valid, s2_res_reg.wb_index, s2_wb_value);
        op_d = pick(s1_instr_reg.dest_index, rd_d_reg, vld_d_reg, ovr_d_reg, ovr_val_reg,
                    s2_valid_reg && s2_res_reg.wb_valid, s2_res_reg.wb_index, s2_wb_value);
    end

    rie_alu u_alu (
        .instr (s1_instr_reg),
        .a     (op_a),
        .b     (op_b),
        .d     (op_d),
        .pc    (pc_reg),
        .epc   (epc_reg),
        .res   (ex_res)
    );

    assign ex_addr = ex_res.mem_address[DMEM_ADDR_BITS-1:0];

    // Register file copies: one serves both source reads, one the store data.
    always_ff @(posedge clk)
    begin
        if (out_fire && s2_res_reg.wb_valid)
        begin
            rf_ab_mem[s2_res_reg.wb_index] <= s2_wb_value;
            rf_d_mem[s2_res_reg.wb_index]  <= s2_wb_value;
        end
        if (in_fire)
        begin
            rd_a_reg <= rf_ab_mem[in_instr.src_index];
            rd_b_reg <= rf_ab_mem[in_instr.second_index];
            rd_d_reg <= rf_d_mem[in_instr.dest_index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            dmem[clr_cnt_reg] <= 16'd0;
        else if (s1_adv && ex_res.mem_kind == MEM_STORE)
            dmem[ex_addr] <= ex_res.mem_data;
        if (s1_adv)
            dmem_rd_reg <= dmem[ex_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == DMEM_ADDR_BITS'(DMEM_DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= '0;
            epc_reg      <= '0;
        end
        else
        begin
            if (out_fire && s2_res_reg.wb_valid)
                rf_vld_reg[s2_res_reg.wb_index] <= 1'b1;
            if (instr.ready)
                s1_valid_reg <= instr.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s1_adv)
            begin
                pc_reg <= ex_res.next_pc;
                if (ex_res.trapped)
                    epc_reg <= pc_reg + PC_STEP;
            end
        end
    end

    // A write retiring on the same edge as the register read is not seen by
    // the read data, so it is captured here as an override.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg <= in_instr;
            vld_a_reg    <= rf_vld_reg[in_instr.src_index];
            vld_b_reg    <= rf_vld_reg[in_instr.second_index];
            vld_d_reg    <= rf_vld_reg[in_instr.dest_index];
            ovr_val_reg  <= s2_wb_value;
            ovr_a_reg    <= out_fire && s2_res_reg.wb_valid
                            && s2_res_reg.wb_index == in_instr.src_index;
            ovr_b_reg    <= out_fire && s2_res_reg.wb_valid
                            && s2_res_reg.wb_index == in_instr.second_index;
            ovr_d_reg    <= out_fire && s2_res_reg.wb_valid
                            && s2_res_reg.wb_index == in_instr.dest_index;
        end
        if (s1_adv)
        begin
            s2_res_reg  <= ex_res;
            s2_load_reg <= ex_res.mem_kind == MEM_LOAD;
        end
    end

    always_comb
    begin
        result.valid = s2_valid_reg;
        result.data  = s2_res_reg;
        if (s2_load_reg)
        begin
            result.data.wb_value = dmem_rd_reg;
            result.data.mem_data = dmem_rd_reg;
        end
    end

endmodule

// File: dv/risc16_instruction_execute_core_test.sv
module risc16_instruction_execute_core_test;
    import rie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DMEM_BITS = 12;
    localparam int DMEM_WORDS = 1 << DMEM_BITS;

    // Mirror of the execute stage: registers, both PCs and data memory.
    class execute_scoreboard;
        logic [15:0] regs [8];
        logic [15:0] pc_q;
        logic [15:0] epc_q;
        logic [15:0] dmem [DMEM_WORDS];
        result_t pending [$];
        int errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            pc_q = '0;
            epc_q = '0;
            errors = 0;
        endfunction

        function automatic logic [15:0] sx(logic [15:0] v, int bits);
            logic [15:0] m;
            m = (16'h1 << bits) - 16'h1;
            v = v & m;
            if (v[bits - 1])
                v = v | ~m;
            return v;
        endfunction

        function automatic logic [15:0] rotl(logic [15:0] v, logic [3:0] n);
            return (n == 0) ? v : ((v << n) | (v >> (16 - n)));
        endfunction

        function automatic logic [15:0] rotr(logic [15:0] v, logic [3:0] n);
            return (n == 0) ? v : ((v >> n) | (v << (16 - n)));
        endfunction

        function automatic logic signed_lt(logic [15:0] a, logic [15:0] b);
            return $signed(a) < $signed(b);
        endfunction

        function void note_instr(instr_t it);
            result_t r;
            logic [15:0] a, b, pc, i5s, i8s;
            logic [16:0] sum;
            a = regs[it.src_index];
            b = regs[it.second_index];
            pc = pc_q + PC_STEP;
            i5s = sx(16'(it.imm_five), 5);
            i8s = sx(16'(it.imm_eight), 8);
            r = '0;
            case (it.cmd)
                OP_NOP: ;
                OP_RTI: pc = epc_q;
                OP_ADDI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a + i5s; end
                OP_SUBI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = i5s - a; end
                OP_XORI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a ^ 16'(it.imm_five); end
                OP_ANDNI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a & ~16'(it.imm_five); end
                OP_ROLI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = rotl(a, it.imm_five[3:0]); end
                OP_SLLI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a << it.imm_five[3:0]; end
                OP_RORI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = rotr(a, it.imm_five[3:0]); end
                OP_SRLI: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a >> it.imm_five[3:0]; end
                OP_ST: begin
                    r.mem_address = a + i5s;
                    r.mem_data = regs[it.dest_index];
                    r.wb_value = r.mem_data;
                    r.mem_kind = MEM_STORE;
                    dmem[r.mem_address[DMEM_BITS-1:0]] = r.mem_data;
                end
                OP_LD: begin
                    r.mem_address = a + i5s;
                    r.mem_data = dmem[r.mem_address[DMEM_BITS-1:0]];
                    r.mem_kind = MEM_LOAD;
                    r.wb_valid = 1'b1; r.wb_index = it.dest_index; r.wb_value = r.mem_data;
                end
                OP_STU: begin
                    // The old base is what gets stored when data and base coincide.
                    r.mem_address = a + i5s;
                    r.mem_data = regs[it.dest_index];
                    r.mem_kind = MEM_STORE;
                    dmem[r.mem_address[DMEM_BITS-1:0]] = r.mem_data;
                    r.wb_valid = 1'b1; r.wb_index = it.src_index; r.wb_value = r.mem_address;
                end
                OP_BTR: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = {<<{a}}; end
                OP_ADD: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a + b; end
                OP_SUB: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = b - a; end
                OP_XOR: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a ^ b; end
                OP_ANDN: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a & ~b; end
                OP_ROL: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = rotl(a, b[3:0]); end
                OP_SLL: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a << b[3:0]; end
                OP_ROR: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = rotr(a, b[3:0]); end
                OP_SRL: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = a >> b[3:0]; end
                OP_SEQ: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = 16'(a == b); end
                OP_SLT: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = 16'(signed_lt(a, b)); end
                OP_SLE: begin r.wb_valid = 1'b1; r.wb_index = it.dest_index;
                    r.wb_value = 16'(signed_lt(a, b) || a == b); end
                OP_SCO: begin
                    sum = {1'b0, a} + {1'b0, b};
                    r.wb_valid = 1'b1; r.wb_index = it.dest_index; r.wb_value = 16'(sum[16]);
                end
                OP_BEQZ: if (a == 0) pc = pc + i8s;
                OP_BNEZ: if (a != 0) pc = pc + i8s;
                OP_BLTZ: if (a[15]) pc = pc + i8s;
                OP_BGEZ: if (!a[15]) pc = pc + i8s;
                OP_LBI: begin r.wb_valid = 1'b1; r.wb_index = it.src_index;
                    r.wb_value = i8s; end
                OP_SLBI: begin r.wb_valid = 1'b1; r.wb_index = it.src_index;
                    r.wb_value = {a[7:0], it.imm_eight}; end
                OP_J: pc = pc + sx(16'(it.displacement), 11);
                OP_JR: pc = a + i8s;
                OP_JAL: begin
                    r.wb_valid = 1'b1; r.wb_index = LINK_REG; r.wb_value = pc;
                    pc = pc + sx(16'(it.displacement), 11);
                end
                OP_JALR: begin
                    r.wb_valid = 1'b1; r.wb_index = LINK_REG; r.wb_value = pc;
                    pc = a + i8s;
                end
                default: begin
                    epc_q = pc;
                    pc = TRAP_PC;
                    r.trapped = 1'b1;
                end
            endcase
            if (r.wb_valid)
                regs[r.wb_index] = r.wb_value;
            pc_q = pc;
            r.next_pc = pc;
            pending.push_back(r);
        endfunction

        function void report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("%0t: %s got %h expected %h", $time, what, got, want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction", $time);
                return;
            end
            want = pending.pop_front();
            if (got.wb_valid !== want.wb_valid)
                report("wb_valid", 16'(got.wb_valid), 16'(want.wb_valid));
            if (got.wb_index !== want.wb_index)
                report("wb_index", 16'(got.wb_index), 16'(want.wb_index));
            if (got.wb_value !== want.wb_value) report("wb_value", got.wb_value, want.wb_value);
            if (got.mem_kind !== want.mem_kind)
                report("mem_kind", 16'(got.mem_kind), 16'(want.mem_kind));
            if (got.mem_address !== want.mem_address)
                report("mem_address", got.mem_address, want.mem_address);
            if (got.mem_data !== want.mem_data) report("mem_data", got.mem_data, want.mem_data);
            if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
            if (got.trapped !== want.trapped)
                report("trapped", 16'(got.trapped), 16'(want.trapped));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rie_chan_if #(.T(instr_t)) instr ();
    rie_chan_if #(.T(result_t)) result ();

    risc16_instruction_execute_core #(.DMEM_ADDR_BITS(DMEM_BITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .instr(instr.sink),
        .result(result.source)
    );

    execute_scoreboard board;
    int hold_off;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int gap_length();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Offer one instruction and hold it until the block takes it.
    task automatic send_instr(instr_t it);
        int g;
        g = gap_length();
        repeat (g) begin
            instr.valid <= 1'b0;
            @(posedge clk);
        end
        instr.valid <= 1'b1;
        instr.data <= it;
        do @(posedge clk); while (!instr.ready);
        board.note_instr(it);
    endtask

    function automatic instr_t make_instr(logic [5:0] cmd);
        instr_t it;
        it.cmd = cmd;
        it.src_index = 3'($urandom_range(7));
        it.second_index = 3'($urandom_range(7));
        it.dest_index = 3'($urandom_range(7));
        it.imm_five = 5'($urandom_range(31));
        it.imm_eight = 8'($urandom_range(255));
        it.displacement = 11'($urandom_range(2047));
        return it;
    endfunction

    task automatic send_op(op_t op, int s, int t, int d, int i5, int i8, int dsp);
        instr_t it;
        it.cmd = op;
        it.src_index = 3'(s);
        it.second_index = 3'(t);
        it.dest_index = 3'(d);
        it.imm_five = 5'(i5);
        it.imm_eight = 8'(i8);
        it.displacement = 11'(dsp);
        send_instr(it);
    endtask

    // Result side: random stalls, plus one long hold-off to fill the pipeline.
    initial begin
        int g;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off > 0) begin
                result.ready <= 1'b0;
                hold_off--;
            end
            else begin
                g = gap_length();
                result.ready <= (g == 0);
            end
            @(posedge clk);
            if (result.valid && result.ready)
                board.check_result(result.data);
        end
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int n;
        int k;
        instr_t it;
        board = new();
        hold_off = 0;
        instr.valid = 1'b0;
        instr.data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, store-update onto its own base, link via r7.
        send_op(OP_LBI, 1, 0, 0, 0, 8'h7F, 0);
        send_op(OP_SLBI, 1, 0, 0, 0, 8'hFF, 0);
        send_op(OP_LBI, 2, 0, 0, 0, 8'h80, 0);
        send_op(OP_ADDI, 1, 0, 3, 5'h1F, 0, 0);
        send_op(OP_SUBI, 2, 0, 4, 5'h10, 0, 0);
        send_op(OP_SCO, 1, 2, 5, 0, 0, 0);
        send_op(OP_ROLI, 1, 0, 6, 0, 0, 0);
        send_op(OP_RORI, 1, 0, 6, 5'h1F, 0, 0);
        send_op(OP_ST, 1, 0, 2, 5'h0F, 0, 0);
        send_op(OP_LD, 1, 0, 3, 5'h0F, 0, 0);
        send_op(OP_STU, 4, 0, 4, 5'h10, 0, 0);
        send_op(OP_LD, 4, 0, 5, 0, 0, 0);
        send_op(OP_BTR, 1, 0, 6, 0, 0, 0);
        send_op(OP_J, 0, 0, 0, 0, 0, 11'h7FF);
        send_op(OP_J, 0, 0, 0, 0, 0, 11'h400);
        send_op(OP_JAL, 0, 0, 0, 0, 0, 11'h3FF);
        send_op(OP_JALR, 7, 0, 0, 0, 8'h80, 0);
        send_op(OP_JR, 7, 0, 0, 0, 8'h7F, 0);
        send_op(OP_SLE, 2, 2, 1, 0, 0, 0);
        send_op(OP_TRAP, 0, 0, 0, 0, 0, 0);
        send_op(OP_RTI, 0, 0, 0, 0, 0, 0);
        it = make_instr(6'd63);
        send_instr(it);
        send_op(OP_RTI, 7, 7, 7, 5'h1F, 8'hFF, 11'h7FF);
        for (k = 0; k <= OP_JALR; k++)
            send_instr(make_instr(6'(k)));

        for (n = 0; n < 1800; n++) begin
            if (n == 600)
                hold_off = 60;
            k = $urandom_range(99);
            if (k < 4)
                it = make_instr(6'($urandom_range(63, 37)));
            else if (k < 20)
                it = make_instr(6'($urandom_range(13, 11)));
            else
                it = make_instr(6'($urandom_range(36, 0)));
            // Keep most memory traffic in a small window so loads find stores.
            if (it.cmd inside {OP_ST, OP_LD, OP_STU} && $urandom_range(3) != 0)
                it.imm_five = 5'($urandom_range(3));
            send_instr(it);
        end
        instr.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
src/rie_pkg.sv
src/rie_chan_if.sv
src/rie_alu.sv
src/risc16_instruction_execute_core.sv
dv/risc16_instruction_execute_core_test.sv
